@@ hw/rtl/ohlc_pkg.sv @@
package ohlc_pkg;

    localparam int BUCKETS_DEF = 64;

    localparam int KEY_W   = 60;
    localparam int PRICE_W = 48;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int US_W    = 37;

    // command codes
    localparam logic CMD_ORDER = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // config register indexes
    localparam logic [1:0] CFG_PRODUCT   = 2'd0;
    localparam logic [1:0] CFG_SIDE      = 2'd1;
    localparam logic [1:0] CFG_TIMEFRAME = 2'd2;

    // timeframe codes
    localparam logic [1:0] TF_DAY   = 2'd0;
    localparam logic [1:0] TF_MONTH = 2'd1;
    localparam logic [1:0] TF_YEAR  = 2'd2;
    localparam logic [1:0] TF_FULL  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_FLUSH
    } state_t;

    // per-bucket payload held by one cell
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   first_stamp;
        logic [PRICE_W-1:0] first_value;
        logic [KEY_W-1:0]   final_stamp;
        logic [PRICE_W-1:0] final_value;
        logic [PRICE_W-1:0] peak_value;
        logic [PRICE_W-1:0] trough_value;
    } cell_data_t;

    // order broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   stamp;
        logic [PRICE_W-1:0] price;
    } order_bc_t;

    // chain-wide control
    typedef struct packed {
        logic apply;   // order update/insert this cycle
        logic hit;     // some cell holds the order's key
        logic full;    // last cell in use
        logic pop;     // shift chain toward the head (flush)
    } cell_ctl_t;

endpackage

@@ hw/rtl/ohlc_candle_aggregator_core.sv @@
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  cmd, product_code, order_side, order_*
// out       source     out_valid/out_stall candle_valid, bucket_*, *_price, flags
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Orders: a matching order is accepted, then applied to the chain in ST_APPLY;
// a filtered order is only accepted. A flush is accepted, then emits its candles
// (at least one), one bucket per cycle while out is not stalled.
// Reset: rst_n async low clears FSM, used bits, overflow flag and config.
// out_stall holds the output register and pauses the flush; a new request is
// taken while a finished candle still waits in the output register.
module ohlc_candle_aggregator_core
    import ohlc_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [7:0]           product_code,
    input  logic                 order_side,
    input  logic [YEAR_W-1:0]    order_year,
    input  logic [MONTH_W-1:0]   order_month,
    input  logic [DAY_W-1:0]     order_day,
    input  logic [US_W-1:0]      order_microsecond,
    input  logic [PRICE_W-1:0]   order_price,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 candle_valid,
    output logic [YEAR_W-1:0]    bucket_year,
    output logic [MONTH_W-1:0]   bucket_month,
    output logic [DAY_W-1:0]     bucket_day,
    output logic [US_W-1:0]      bucket_microsecond,
    output logic [PRICE_W-1:0]   open_price,
    output logic [PRICE_W-1:0]   high_price,
    output logic [PRICE_W-1:0]   low_price,
    output logic [PRICE_W-1:0]   close_price,
    output logic                 last_candle,
    output logic                 table_overflow,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [7:0] product_reg;
    logic       side_reg;
    logic [1:0] timeframe_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_reg   <= '0;
            side_reg      <= 1'b0;
            timeframe_reg <= TF_DAY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRODUCT:   product_reg   <= cfg_data;
                CFG_SIDE:      side_reg      <= cfg_data[0];
                CFG_TIMEFRAME: timeframe_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request intake: filter, key truncation, broadcast register
    // ------------------------------------------------------------------
    state_t    state_reg, state_next;
    order_bc_t bc_reg, bc_next;
    logic      overflow_reg, overflow_next;

    logic in_take;
    logic order_match;
    logic [KEY_W-1:0] stamp_in;
    logic [KEY_W-1:0] key_in;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign order_match = (product_code == product_reg) && (order_side == side_reg);
    assign stamp_in    = {order_year, order_month, order_day, order_microsecond};

    always_comb
    begin
        unique case (timeframe_reg)
            TF_DAY:   key_in = {order_year, order_month, order_day, {US_W{1'b0}}};
            TF_MONTH: key_in = {order_year, order_month, {(DAY_W + US_W){1'b0}}};
            TF_YEAR:  key_in = {order_year, {(MONTH_W + DAY_W + US_W){1'b0}}};
            TF_FULL:  key_in = stamp_in;
            default:  key_in = stamp_in;
        endcase
    end

    // ------------------------------------------------------------------
    // cell chain: cell 0 holds the smallest key, used cells form a prefix
    // ------------------------------------------------------------------
    cell_ctl_t  ctl;
    logic       used_q  [BUCKETS];
    cell_data_t data_q  [BUCKETS];
    logic       lt_q    [BUCKETS];
    logic [BUCKETS-1:0] eq_vec;
    logic [BUCKETS-1:0] used_vec;

    genvar g;
    generate
        for (g = 0; g < BUCKETS; g++)
        begin : g_cell
            logic       p_lt, p_used, n_used;
            cell_data_t p_data, n_data;

            if (g == 0)
            begin : g_head
                assign p_lt   = 1'b1;   // nothing ahead of the head
                assign p_used = 1'b0;
                assign p_data = '0;
            end
            else
            begin : g_body
                assign p_lt   = lt_q[g-1];
                assign p_used = used_q[g-1];
                assign p_data = data_q[g-1];
            end

            if (g == BUCKETS - 1)
            begin : g_tail
                assign n_used = 1'b0;
                assign n_data = '0;
            end
            else
            begin : g_mid
                assign n_used = used_q[g+1];
                assign n_data = data_q[g+1];
            end

            logic c_eq;

            ohlc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .bc        (bc_reg),
                .prev_lt   (p_lt),
                .prev_used (p_used),
                .prev_data (p_data),
                .next_used (n_used),
                .next_data (n_data),
                .used      (used_q[g]),
                .data      (data_q[g]),
                .lt        (lt_q[g]),
                .eq        (c_eq)
            );

            assign eq_vec[g]   = c_eq;
            assign used_vec[g] = used_q[g];
        end
    endgenerate

    // head's successor decides whether the popped candle is the last one
    logic second_used;
    generate
        if (BUCKETS > 1)
        begin : g_second
            assign second_used = used_q[1];
        end
        else
        begin : g_single
            assign second_used = 1'b0;
        end
    endgenerate

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    logic out_load;

    typedef struct packed {
        logic               candle_valid;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic               last;
        logic               overflow;
    } out_word_t;

    out_word_t out_reg, out_next;

    assign out_load = (state_reg == ST_FLUSH) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // control FSM
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        overflow_next  = overflow_reg;
        ctl            = '0;
        ctl.hit        = |eq_vec;
        ctl.full       = used_q[BUCKETS-1];
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (cmd == CMD_FLUSH)
                        state_next = ST_FLUSH;
                    else if (order_match)
                    begin
                        bc_next.key   = key_in;
                        bc_next.stamp = stamp_in;
                        bc_next.price = order_price;
                        state_next    = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                ctl.apply = 1'b1;
                if (!ctl.hit && ctl.full)
                    overflow_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (out_load)
                begin
                    ctl.pop               = 1'b1;
                    out_valid_next        = 1'b1;
                    out_next.candle_valid = used_q[0];
                    out_next.overflow     = overflow_reg;
                    if (used_q[0])
                    begin
                        out_next.key     = data_q[0].key;
                        out_next.open_p  = data_q[0].first_value;
                        out_next.high_p  = data_q[0].peak_value;
                        out_next.low_p   = data_q[0].trough_value;
                        out_next.close_p = data_q[0].final_value;
                        out_next.last    = !second_used;
                    end
                    else
                    begin
                        // empty table: a single blank candle
                        out_next.key     = '0;
                        out_next.open_p  = '0;
                        out_next.high_p  = '0;
                        out_next.low_p   = '0;
                        out_next.close_p = '0;
                        out_next.last    = 1'b1;
                    end
                    if (out_next.last)
                    begin
                        overflow_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bc_reg  <= bc_next;
        out_reg <= out_next;
    end

    assign out_valid          = out_valid_reg;
    assign candle_valid       = out_reg.candle_valid;
    assign bucket_year        = out_reg.key[KEY_W-1 -: YEAR_W];
    assign bucket_month       = out_reg.key[US_W + DAY_W +: MONTH_W];
    assign bucket_day         = out_reg.key[US_W +: DAY_W];
    assign bucket_microsecond = out_reg.key[US_W-1:0];
    assign open_price         = out_reg.open_p;
    assign high_price         = out_reg.high_p;
    assign low_price          = out_reg.low_p;
    assign close_price        = out_reg.close_p;
    assign last_candle        = out_reg.last;
    assign table_overflow     = out_reg.overflow;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // occupied cells always form a prefix of the chain
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((used_vec >> 1) & ~used_vec) == '0)
        else $error("bucket chain has a hole");

    // a flush request moves straight into the flush sequence
    a_flush_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_FLUSH) |=> (state_reg == ST_FLUSH))
        else $error("flush request not started");

    // a blank candle only ever closes a flush
    a_blank_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !candle_valid) |-> last_candle)
        else $error("blank candle not marked last");

    // overflow can only rise while the chain is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_reg) |-> $past(used_vec[BUCKETS-1]))
        else $error("overflow set with free cells");

endmodule

@@ hw/rtl/ohlc_cell.sv @@
module ohlc_cell
    import ohlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  order_bc_t  bc,
    input  logic       prev_lt,
    input  logic       prev_used,
    input  cell_data_t prev_data,
    input  logic       next_used,
    input  cell_data_t next_data,
    output logic       used,
    output cell_data_t data,
    output logic       lt,
    output logic       eq
);

    logic       used_reg, used_next;
    cell_data_t data_reg, data_next;

    assign used = used_reg;
    assign data = data_reg;
    assign lt   = used_reg && (data_reg.key < bc.key);
    assign eq   = used_reg && (data_reg.key == bc.key);

    always_comb
    begin
        used_next = used_reg;
        data_next = data_reg;
        if (ctl.pop)
        begin
            used_next = next_used;
            data_next = next_data;
        end
        else if (ctl.apply && ctl.hit)
        begin
            if (eq)
            begin
                if (bc.stamp < data_reg.first_stamp)
                begin
                    data_next.first_stamp = bc.stamp;
                    data_next.first_value = bc.price;
                end
                // ties go to the later arrival
                if (bc.stamp >= data_reg.final_stamp)
                begin
                    data_next.final_stamp = bc.stamp;
                    data_next.final_value = bc.price;
                end
                if (bc.price > data_reg.peak_value)
                    data_next.peak_value = bc.price;
                if (bc.price < data_reg.trough_value)
                    data_next.trough_value = bc.price;
            end
        end
        else if (ctl.apply && !ctl.full)
        begin
            if (!prev_lt)
            begin
                used_next = prev_used;
                data_next = prev_data;
            end
            else if (!lt)
            begin
                used_next              = 1'b1;
                data_next.key          = bc.key;
                data_next.first_stamp  = bc.stamp;
                data_next.first_value  = bc.price;
                data_next.final_stamp  = bc.stamp;
                data_next.final_value  = bc.price;
                data_next.peak_value   = bc.price;
                data_next.trough_value = bc.price;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
